@@ src/mrlb_pkg.sv @@
package mrlb_pkg;

  localparam int IDX_W   = 13;
  localparam int CNT_W   = 14;
  localparam int PFX_W   = 20;
  localparam int COST_W  = 48;
  localparam int WIDTH_W = 8;
  localparam int LEN_W   = 6;
  localparam int SLACK_W = PFX_W + 3;
  localparam int LCUBE_W = 3 * WIDTH_W;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 80;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd80;
  localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // per-item context for the candidate pipeline
  typedef struct packed {
    logic               clear;
    logic               last;
    logic [WIDTH_W-1:0] width;
    logic [PFX_W-1:0]   pj;
  } eval_ctl_t;

  // one line start, issued with the ring read of the word before it
  typedef struct packed {
    logic             vld;
    logic             ent;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] gap;
  } cand_t;

  typedef struct packed {
    logic              busy;
    logic [COST_W-1:0] cost;
    logic [CNT_W-1:0]  start;
  } eval_sts_t;

endpackage

@@ src/mrlb_ram.sv @@
module mrlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mrlb_eval.sv @@
module mrlb_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mrlb_pkg::eval_ctl_t              ctl_i,
  input  mrlb_pkg::cand_t                  cand_i,
  input  logic [mrlb_pkg::PFX_W-1:0]       rd_prefix_i,
  input  logic [mrlb_pkg::COST_W-1:0]      rd_cost_i,
  output mrlb_pkg::eval_sts_t              sts_o
);

  logic [mrlb_pkg::PFX_W-1:0]   prefix_c;
  logic [mrlb_pkg::COST_W-1:0]  before_c;
  logic [mrlb_pkg::PFX_W-1:0]   sum_c;
  logic [mrlb_pkg::SLACK_W-1:0] slack_c;
  logic                         ok_c;

  logic                           s1_vld_q, s2_vld_q, s3_vld_q;
  logic [mrlb_pkg::WIDTH_W-1:0]   s1_slack_q, s2_slack_q;
  logic [mrlb_pkg::COST_W-1:0]    s1_before_q, s2_before_q, s3_before_q;
  logic [mrlb_pkg::CNT_W-1:0]     s1_start_q, s2_start_q, s3_start_q;
  logic [2*mrlb_pkg::WIDTH_W-1:0] s2_sq_q;
  logic [mrlb_pkg::LCUBE_W-1:0]   s3_cube_q;

  logic [mrlb_pkg::COST_W-1:0]    lc_c;
  logic [mrlb_pkg::COST_W:0]      sum_cost_c;
  logic [mrlb_pkg::COST_W-1:0]    cand_cost_c;

  logic [mrlb_pkg::COST_W-1:0]    best_q;
  logic [mrlb_pkg::CNT_W-1:0]     best_start_q;

  // an entry that was never written since the last clear reads as zero
  always_comb begin
    prefix_c = cand_i.ent ? rd_prefix_i : '0;
    before_c = cand_i.ent ? rd_cost_i : '0;
    sum_c    = ctl_i.pj - prefix_c;
    slack_c  = {{(mrlb_pkg::SLACK_W-mrlb_pkg::WIDTH_W){1'b0}}, ctl_i.width}
             - {{(mrlb_pkg::SLACK_W-mrlb_pkg::CNT_W){1'b0}}, cand_i.gap}
             - {{(mrlb_pkg::SLACK_W-mrlb_pkg::PFX_W){1'b0}}, sum_c};
    ok_c     = cand_i.vld && !slack_c[mrlb_pkg::SLACK_W-1]
            && (before_c != mrlb_pkg::COST_MAX);
  end

  always_comb begin
    lc_c        = ctl_i.last ? '0 : mrlb_pkg::COST_W'(s3_cube_q);
    sum_cost_c  = {1'b0, s3_before_q} + {1'b0, lc_c};
    cand_cost_c = (sum_cost_c >= {1'b0, mrlb_pkg::COST_MAX}) ? mrlb_pkg::COST_MAX
                                                            : sum_cost_c[mrlb_pkg::COST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ok_c;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // slack fits 8 bits once known non-negative: it never exceeds the width
  always_ff @(posedge clk_i) begin
    s1_slack_q  <= slack_c[mrlb_pkg::WIDTH_W-1:0];
    s1_before_q <= before_c;
    s1_start_q  <= cand_i.start;

    s2_sq_q     <= (2*mrlb_pkg::WIDTH_W)'(s1_slack_q) * (2*mrlb_pkg::WIDTH_W)'(s1_slack_q);
    s2_slack_q  <= s1_slack_q;
    s2_before_q <= s1_before_q;
    s2_start_q  <= s1_start_q;

    s3_cube_q   <= mrlb_pkg::LCUBE_W'(s2_sq_q) * mrlb_pkg::LCUBE_W'(s2_slack_q);
    s3_before_q <= s2_before_q;
    s3_start_q  <= s2_start_q;
  end

  // starts arrive in ascending order, strict compare keeps the earliest
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      best_q       <= mrlb_pkg::COST_MAX;
      best_start_q <= '0;
    end else if (s3_vld_q && (cand_cost_c < best_q)) begin
      best_q       <= cand_cost_c;
      best_start_q <= s3_start_q;
    end
  end

  always_comb begin
    sts_o.busy  = cand_i.vld | s1_vld_q | s2_vld_q | s3_vld_q;
    sts_o.cost  = best_q;
    sts_o.start = best_start_q;
  end

endmodule

@@ src/min_raggedness_line_break.sv @@
// Minimum-raggedness line breaker, cubic slack penalty.
// Input stream: one word per paragraph word; tdata[5:0] holds its length and
// tlast marks the final word. Output stream: one word per input word with the
// word index, the least total cost up to it and the start of the best line
// ending on it; tuser is the fits flag, tlast closes the paragraph.
// cfg_we_i/cfg_wdata_i load the line width (80 after reset); the user is to load
// it only while idle, which the block itself does not enforce. Each word reads
// the prefix/cost ring once per candidate line start through the single RAM
// read port, n = min((line_width+1)/2, WINDOW, word index) starts per word.
// No new word is taken while one is in flight.
// A 4-stage pipeline (slack, square, cube, min) follows the read port.
// The input is taken again once the result sits in the output register, so
// the next word is scanned while the receiver holds off. A stalled receiver
// blocks only the following result; words stay queued at the input.
// Reset clears the ring valid bits, word count and running prefix at once;
// the ring is likewise invalidated after each paragraph's last word.
module min_raggedness_line_break #(
  parameter int unsigned MAX_WORDS    = 4096,
  parameter int unsigned WINDOW       = 128,
  parameter int unsigned MAX_WORD_LEN = 63
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mrlb_pkg::WIDTH_W-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mrlb_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // word_length[5:0], zero pad
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mrlb_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // word_index[12:0],
                                                          // total_cost[60:13],
                                                          // line_start[73:61], zero pad
  output logic                             m_axis_tuser,  // fits
  output logic                             m_axis_tlast
);

  localparam int AW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int RAM_W = mrlb_pkg::PFX_W + mrlb_pkg::COST_W;

  mrlb_pkg::state_e state_q, state_d;

  logic [mrlb_pkg::WIDTH_W-1:0] width_q;
  logic [mrlb_pkg::IDX_W-1:0]   word_count_q;
  logic [mrlb_pkg::PFX_W-1:0]   run_prefix_q;
  logic [AW-1:0]                cur_slot_q;
  logic [WINDOW-1:0]            valid_q;

  logic [mrlb_pkg::CNT_W-1:0]   j_q, i_q, dist_q;
  logic [mrlb_pkg::PFX_W-1:0]   pj_q;
  logic                         last_q;
  logic [CW-1:0]                n_q;
  logic [AW-1:0]                rd_slot_q;

  logic                         iss_vld_q, iss_ent_q;
  logic [mrlb_pkg::CNT_W-1:0]   iss_start_q, iss_dist_q;

  logic                         m_valid_q, m_user_q, m_last_q;
  logic [mrlb_pkg::M_TDATA_W-1:0] m_data_q;

  logic accept, issue, finish, out_free;

  // word setup
  logic [mrlb_pkg::CNT_W-1:0] j_c, lo_c, dist0_c;
  logic                       last_c;
  logic [mrlb_pkg::LEN_W-1:0] len_c;
  logic [mrlb_pkg::PFX_W-1:0] pj_c;
  logic [mrlb_pkg::WIDTH_W:0] half_c;
  logic [CW-1:0]              span_c, n_c;
  logic [CW+1:0]              sdiff_c, sfix_c;
  logic [AW-1:0]              slot0_c, wslot_c;

  mrlb_pkg::eval_ctl_t ctl;
  mrlb_pkg::cand_t     cand;
  mrlb_pkg::eval_sts_t sts;

  logic [RAM_W-1:0] rdata;
  logic [mrlb_pkg::COST_W-1:0] fin_cost_c;
  logic                        fin_fits_c;
  logic [mrlb_pkg::IDX_W-1:0]  fin_start_c;

  always_comb begin
    j_c    = {1'b0, word_count_q} + mrlb_pkg::CNT_W'(1);
    last_c = s_axis_tlast || (32'(j_c) >= MAX_WORDS);
    len_c  = (32'(s_axis_tdata[mrlb_pkg::LEN_W-1:0]) > MAX_WORD_LEN)
           ? mrlb_pkg::LEN_W'(MAX_WORD_LEN) : s_axis_tdata[mrlb_pkg::LEN_W-1:0];
    pj_c   = run_prefix_q + mrlb_pkg::PFX_W'(len_c);
    half_c = ({1'b0, width_q} + (mrlb_pkg::WIDTH_W+1)'(1)) >> 1;
    span_c = (32'(half_c) > WINDOW) ? CW'(WINDOW) : CW'(half_c);
    // ring slot of the word before the earliest start, one wrap at most
    sdiff_c = {2'b00, CW'(cur_slot_q)} + (CW+2)'(1) - {2'b00, span_c};
    sfix_c  = sdiff_c[CW+1] ? sdiff_c + (CW+2)'(WINDOW) : sdiff_c;
    if (32'(j_c) >= 32'(span_c)) begin
      n_c     = span_c;
      slot0_c = sfix_c[AW-1:0];
      lo_c    = j_c + mrlb_pkg::CNT_W'(1) - mrlb_pkg::CNT_W'(span_c);
    end else begin
      n_c     = CW'(j_c);
      slot0_c = '0;
      lo_c    = mrlb_pkg::CNT_W'(1);
    end
    dist0_c = mrlb_pkg::CNT_W'(n_c) - mrlb_pkg::CNT_W'(1);
    wslot_c = (cur_slot_q == AW'(WINDOW - 1)) ? '0 : cur_slot_q + AW'(1);
  end

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mrlb_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (n_c == '0) ? mrlb_pkg::ST_DRAIN : mrlb_pkg::ST_SCAN;
        end
      end
      mrlb_pkg::ST_SCAN: begin
        if (n_q == CW'(1)) begin
          state_d = mrlb_pkg::ST_DRAIN;
        end
      end
      mrlb_pkg::ST_DRAIN: begin
        if (!sts.busy) begin
          state_d = mrlb_pkg::ST_FINISH;
        end
      end
      mrlb_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = mrlb_pkg::ST_IDLE;
        end
      end
      default: state_d = mrlb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == mrlb_pkg::ST_IDLE);
    accept        = s_axis_tready && s_axis_tvalid;
    issue         = (state_q == mrlb_pkg::ST_SCAN);
    finish        = (state_q == mrlb_pkg::ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrlb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mrlb_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // paragraph state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
      run_prefix_q <= '0;
      cur_slot_q   <= '0;
      valid_q      <= '0;
    end else if (finish) begin
      if (last_q) begin
        word_count_q <= '0;
        run_prefix_q <= '0;
        cur_slot_q   <= '0;
        valid_q      <= '0;
      end else begin
        word_count_q       <= j_q[mrlb_pkg::IDX_W-1:0];
        run_prefix_q       <= pj_q;
        // count wrap restarts the slot sequence at zero
        cur_slot_q         <= (j_q[mrlb_pkg::IDX_W-1:0] == '0) ? '0 : wslot_c;
        valid_q[wslot_c]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      j_q       <= j_c;
      pj_q      <= pj_c;
      last_q    <= last_c;
      n_q       <= n_c;
      rd_slot_q <= slot0_c;
      i_q       <= lo_c;
      dist_q    <= dist0_c;
    end else if (issue) begin
      n_q       <= n_q - CW'(1);
      rd_slot_q <= (rd_slot_q == AW'(WINDOW - 1)) ? '0 : rd_slot_q + AW'(1);
      i_q       <= i_q + mrlb_pkg::CNT_W'(1);
      dist_q    <= dist_q - mrlb_pkg::CNT_W'(1);
    end
  end

  // candidate tag travels alongside the registered RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q <= 1'b0;
    end else begin
      iss_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_ent_q   <= valid_q[rd_slot_q];
    iss_start_q <= i_q;
    iss_dist_q  <= dist_q;
  end

  mrlb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (finish && !last_q),
    .waddr_i (wslot_c),
    .wdata_i ({pj_q, sts.cost}),
    .re_i    (issue),
    .raddr_i (rd_slot_q),
    .rdata_o (rdata)
  );

  always_comb begin
    ctl.clear  = accept;
    ctl.last   = last_q;
    ctl.width  = width_q;
    ctl.pj     = pj_q;
    cand.vld   = iss_vld_q;
    cand.ent   = iss_ent_q;
    cand.start = iss_start_q;
    cand.gap   = iss_dist_q;
  end

  mrlb_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cand_i      (cand),
    .rd_prefix_i (rdata[RAM_W-1:mrlb_pkg::COST_W]),
    .rd_cost_i   (rdata[mrlb_pkg::COST_W-1:0]),
    .sts_o       (sts)
  );

  always_comb begin
    fin_cost_c  = sts.cost;
    fin_fits_c  = (sts.cost != mrlb_pkg::COST_MAX);
    fin_start_c = fin_fits_c ? sts.start[mrlb_pkg::IDX_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      m_data_q <= {6'd0, fin_start_c, fin_cost_c, j_q[mrlb_pkg::IDX_W-1:0]};
      m_user_q <= fin_fits_c;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

@@ src/mrlb_checker.sv @@
module mrlb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mrlb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  // fits flag agrees with a finite cost
  a_fits_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[60:13] != {48{1'b1}})))
    else $error("fits flag disagrees with total cost");

  // a feasible word has a start in 1..word_index, an infeasible one none
  a_start_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ? ((m_axis_tdata[73:61] != 13'd0)
                                       && (m_axis_tdata[73:61] <= m_axis_tdata[12:0]))
                                    : (m_axis_tdata[73:61] == 13'd0)))
    else $error("line start out of range");

  // one word at a time: the input closes right after a word is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a word is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser)))
    else $error("stalled output word changed");

endmodule

bind min_raggedness_line_break mrlb_checker u_mrlb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/line_break_checker.sv @@
module line_break_checker #(
  parameter int unsigned MAX_WORDS = 4096,
  parameter int unsigned WINDOW    = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mrlb_pkg::WIDTH_W-1:0]        cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [mrlb_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [mrlb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                m_axis_tuser,
  input  logic                                m_axis_tlast,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o,
  output int unsigned                         results_o,
  output int unsigned                         infeasible_o,
  output int unsigned                         paragraphs_o
);
  import mrlb_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  word_index;
    logic [COST_W-1:0] total_cost;
    logic [IDX_W-1:0]  line_start;
    logic              fits;
    logic              last_word;
  } break_result_t;

  // running paragraph state, mirrored from the accepted input words
  logic [PFX_W-1:0]   prefix_sums [WINDOW];
  logic [COST_W-1:0]  best_costs  [WINDOW];
  int unsigned        words_seen;
  logic [PFX_W-1:0]   prefix_now;
  logic [WIDTH_W-1:0] width_q;

  break_result_t      expected_breaks [$];
  int unsigned        n_bad, n_results, n_infeasible, n_paragraphs;

  function automatic void clear_paragraph();
    int unsigned k;
    for (k = 0; k < WINDOW; k++) begin
      prefix_sums[k] = '0;
      best_costs[k]  = '0;
    end
    words_seen = 0;
    prefix_now = '0;
  endfunction

  // best break ending on the new word; updates the paragraph state
  function automatic break_result_t break_word(input logic [LEN_W-1:0] len,
                                               input logic last_in);
    int unsigned        j, span, lo, i, slot, best_start;
    logic               closing;
    logic [PFX_W-1:0]   pj, line_sum;
    logic [COST_W-1:0]  best, prior;
    longint             slack;
    longint unsigned    cube, cand;
    break_result_t      r;
    j          = words_seen + 1;
    closing    = last_in || (j >= MAX_WORDS);
    pj         = prefix_now + PFX_W'(len);
    best       = COST_MAX;
    best_start = 0;
    span       = (int'(width_q) + 1) / 2;
    if (span > WINDOW) span = WINDOW;
    lo = (j + 1 > span) ? j + 1 - span : 1;
    for (i = lo; span > 0 && i <= j; i++) begin
      slot     = (i - 1) % WINDOW;
      prior    = best_costs[slot];
      line_sum = pj - prefix_sums[slot];
      slack    = longint'(width_q) - longint'(j) + longint'(i) - longint'(line_sum);
      if (slack >= 0 && prior != COST_MAX) begin
        cube = closing ? 64'd0 : longint'(slack * slack * slack);
        cand = 64'(prior) + cube;
        if (cand >= 64'(COST_MAX)) cand = 64'(COST_MAX);
        // strict compare keeps the earliest start on ties
        if (cand < 64'(best)) begin
          best       = COST_W'(cand);
          best_start = i;
        end
      end
    end
    r.word_index = IDX_W'(j);
    r.total_cost = best;
    r.fits       = (best != COST_MAX);
    r.line_start = r.fits ? IDX_W'(best_start) : '0;
    r.last_word  = closing;
    if (closing) begin
      clear_paragraph();
    end else begin
      slot              = j % WINDOW;
      prefix_sums[slot] = pj;
      best_costs[slot]  = best;
      prefix_now        = pj;
      words_seen        = j % (1 << IDX_W);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    break_result_t got, want;
    if (!rst_ni) begin
      clear_paragraph();
      width_q = WIDTH_RESET;
      expected_breaks.delete();
      n_bad        = 0;
      n_results    = 0;
      n_infeasible = 0;
      n_paragraphs = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.word_index = m_axis_tdata[IDX_W-1:0];
        got.total_cost = m_axis_tdata[IDX_W+COST_W-1:IDX_W];
        got.line_start = m_axis_tdata[2*IDX_W+COST_W-1:IDX_W+COST_W];
        got.fits       = m_axis_tuser;
        got.last_word  = m_axis_tlast;
        n_results++;
        if (expected_breaks.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result word: idx %0d cost %0d start %0d fits %b last %b",
                     got.word_index, got.total_cost, got.line_start, got.fits,
                     got.last_word);
        end else begin
          want = expected_breaks.pop_front();
          if (!want.fits) n_infeasible++;
          if (want.last_word) n_paragraphs++;
          if (got.word_index != want.word_index || got.total_cost != want.total_cost ||
              got.line_start != want.line_start || got.fits != want.fits ||
              got.last_word != want.last_word) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("result %0d: exp idx %0d cost %0d start %0d fits %b last %b",
                       n_results, want.word_index, want.total_cost, want.line_start,
                       want.fits, want.last_word);
              $display("result %0d: got idx %0d cost %0d start %0d fits %b last %b",
                       n_results, got.word_index, got.total_cost, got.line_start,
                       got.fits, got.last_word);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_breaks.push_back(break_word(s_axis_tdata[LEN_W-1:0], s_axis_tlast));
      if (cfg_we_i) width_q = cfg_wdata_i;
    end
    mismatches_o <= n_bad;
    pending_o    <= expected_breaks.size();
    results_o    <= n_results;
    infeasible_o <= n_infeasible;
    paragraphs_o <= n_paragraphs;
  end

endmodule

@@ tb/sv/min_raggedness_line_break_tb.sv @@
module min_raggedness_line_break_tb;
  import mrlb_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [WIDTH_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  int unsigned mismatches, pending, results, infeasible, paragraphs;
  int unsigned send_idle_pct, recv_idle_pct, words_sent, cur_width;

  min_raggedness_line_break uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  line_break_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .results_o     (results),
    .infeasible_o  (infeasible),
    .paragraphs_o  (paragraphs)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // valid stays high between back-to-back words; lowered only for gaps
  task automatic send_word(input logic [LEN_W-1:0] len, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-LEN_W){1'b0}}, len};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // hold the input until every predicted result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_width(input logic [WIDTH_W-1:0] w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    cur_width = 32'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly words that fit the width, a few overlong ones that break the paragraph
  task automatic send_paragraph(input int unsigned n_words);
    int unsigned cap, k;
    logic [LEN_W-1:0] len;
    cap = cur_width / 2;
    if (cap < 1) cap = 1;
    if (cap > 63) cap = 63;
    for (k = 0; k < n_words; k++) begin
      if ($urandom_range(0, 99) < 3) len = LEN_W'($urandom_range(1, 63));
      else len = LEN_W'($urandom_range(1, cap));
      send_word(len, k == n_words - 1);
    end
  endtask

  task automatic run_segment(input int unsigned n_items);
    int unsigned target, pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) load_width(WIDTH_W'($urandom_range(1, 48)));
    else if (pick < 9) load_width(WIDTH_W'($urandom_range(49, 128)));
    else load_width(WIDTH_W'($urandom_range(129, 255)));
    target = words_sent + n_items;
    while (words_sent < target)
      send_paragraph(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 20));
  endtask

  initial begin
    int unsigned k;
    send_idle_pct = 36;
    recv_idle_pct = 76;
    words_sent    = 0;
    cur_width     = 32'(WIDTH_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width: longest words, a single-word paragraph, a run of short words
    send_word(6'd63, 1'b0);
    send_word(6'd1, 1'b0);
    send_word(6'd63, 1'b1);
    send_word(6'd63, 1'b1);
    for (k = 0; k < 8; k++) send_word(6'd1, k == 7);
    // overlong word, then starts that follow an infeasible word
    load_width(8'd40);
    send_word(6'd10, 1'b0);
    send_word(6'd50, 1'b0);
    send_word(6'd5, 1'b0);
    send_word(6'd5, 1'b1);
    // no starts at all
    load_width(8'd0);
    send_word(6'd3, 1'b0);
    send_word(6'd4, 1'b1);
    load_width(8'd1);
    send_word(6'd1, 1'b0);
    send_word(6'd1, 1'b0);
    send_word(6'd2, 1'b0);
    send_word(6'd1, 1'b1);
    // full window and ring wrap
    load_width(8'd255);
    send_paragraph(150);

    for (k = 0; k < 4; k++) run_segment(95);
    send_idle_pct = 76;
    recv_idle_pct = 36;
    for (k = 0; k < 4; k++) run_segment(95);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < 4; k++) run_segment(95);

    // two-character lines
    load_width(8'd2);
    send_paragraph(5);

    settle();
    repeat (150) @(posedge clk);
    $display("Sent %0d words, checked %0d results in %0d paragraphs (%0d infeasible)",
             words_sent, results, paragraphs, infeasible);
    $display("Line widths 0, 1, 2, 40, 80, 255 and random, with stalls on both sides");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
